[rtl/kti_pkg.sv]
// Package for the keyframe track interpolator: sizes, payload structs, states.
// No dependencies.
`timescale 1ns / 1ps
package kti_pkg;
	localparam int NUM_TRACKS = 8;
	localparam int MAX_KEYS   = 16;
	localparam int TW = $clog2(NUM_TRACKS);
	localparam int KW = $clog2(MAX_KEYS);
	localparam int AW = TW + KW;
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int DEPTH = NUM_TRACKS * MAX_KEYS;
	localparam logic [16:0] ONE_Q15 = 17'd32768;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_EVAL   = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [2:0]  track_id;
		logic [15:0] time_q;
		logic signed [15:0] key_value;
		logic [15:0] blend_weight;
	} kti_in_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  out_track;
		logic signed [15:0] sample_value;
		logic        status;
		logic        last;
	} kti_out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_I_RD, ST_I_SCAN, ST_I_SHRD, ST_I_SHWR, ST_I_DONE,
		ST_E_TRK, ST_E_RD, ST_E_SCAN, ST_E_MUL1, ST_E_MUL2, ST_E_DIV,
		ST_E_FIN, ST_OUT
	} kti_state_t;
endpackage

[rtl/kti_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module kti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

[rtl/kti_div.sv]
// Restoring divider, one quotient bit per cycle: trunc(num / (den * 32768)).
// No dependencies.
`timescale 1ns / 1ps
module kti_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [49:0] num,
	input  logic signed [16:0] den,
	output logic               done,
	output logic signed [33:0] quo
);
	logic [32:0] dvd_q, q_q;
	logic [15:0] dvs_q;
	logic [15:0] rem_q;
	logic        neg_q, busy_q;
	logic [5:0]  cnt_q;
	logic [16:0] shifted;
	logic [17:0] trial;
	logic [49:0] mag;
	logic [16:0] dmag;

	assign mag  = num[49] ? -num : num;
	assign dmag = den[16] ? -den : den;
	assign shifted = {rem_q, dvd_q[32]};
	assign trial = {1'b0, shifted} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// drop the 2^15 scale first; truncation of magnitudes composes
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[49] ^ den[16];
			dvd_q <= mag[47:15];
			dvs_q <= dmag[15:0];
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[31:0], 1'b0};
			if (!trial[17]) begin
				rem_q <= trial[15:0];
				q_q   <= {q_q[31:0], 1'b1};
			end else begin
				rem_q <= shifted[15:0];
				q_q   <= {q_q[31:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
endmodule

[rtl/keyframe_track_interpolator.sv]
// Top level: keyframe store in two RAMs, insert sequencer and evaluator.
// Depends on kti_pkg, kti_ram, kti_div.
//
//  channel   dir   handshake        payload
//  in        in    in_valid/stall   kti_in_t
//  out       out   out_valid/stall  kti_out_t
//  cfg       in    cfg_valid/ready  use_blend_weight bit
//
// Insert: compare keys in turn, shift later keys up a slot, then write the new key.
// Evaluate: per non-empty track a scan for the keys around the query time, the multiply
// states ST_E_MUL1 and ST_E_MUL2, the 33-step divider and a finish state.
// Reset clears key counts, the weight enable and the sequencer; key RAMs are not cleared.
// A stalled output holds the sequencer; one request is in work at a time.
`timescale 1ns / 1ps
module keyframe_track_interpolator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  kti_pkg::kti_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output kti_pkg::kti_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import kti_pkg::*;

	kti_state_t st_q, st_d;
	kti_in_t    req_q;
	logic       wen_q;
	logic [CW-1:0] cnt_q [NUM_TRACKS];
	logic [CW-1:0] n_q, k_q, j_q;
	logic [TW-1:0] trk_q;
	logic [15:0] t1_q, t2_q;
	logic signed [15:0] v1_q;
	logic signed [16:0] v2_q;
	logic signed [16:0] dd_q;
	logic signed [32:0] p1_q;
	logic signed [49:0] p2_q;
	logic       div_go_q, div_done;
	logic signed [33:0] quo;
	logic       wr_q, add_q;
	kti_out_t   pend_q;
	logic       pend_v_q;
	logic       ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0] rt, rv, wt, wv;
	logic [15:0] wgt;
	logic [KW-1:0] kidx;
	logic [TW-1:0] itrk;
	logic       trk_ok;
	logic       last_trk;
	logic signed [17:0] dv, dt;
	logic signed [34:0] sum;
	logic signed [15:0] sat;

	kti_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_time (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wt), .rdata(rt));
	kti_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_val (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wv), .rdata(rv));

	kti_div u_div (.clk(clk), .arst_n(arst_n), .start(div_go_q),
		.num(p2_q), .den(dd_q), .done(div_done), .quo(quo));

	assign cfg_ready = (st_q == ST_IDLE);
	assign in_stall  = (st_q != ST_IDLE);

	assign wgt = wen_q ? req_q.blend_weight : ONE_Q15[15:0];
	assign kidx = KW'(k_q);
	assign itrk = TW'(req_q.track_id);
	assign trk_ok = 32'(req_q.track_id) < NUM_TRACKS;
	assign last_trk = (trk_q == TW'(NUM_TRACKS - 1));

	assign dv = {v2_q[16], v2_q} - {{2{v1_q[15]}}, v1_q};
	assign dt = $signed({2'b0, req_q.time_q} - {2'b0, t1_q});

	// sum with saturation
	assign sum = {{19{v1_q[15]}}, v1_q} + {quo[33], quo};
	assign sat = (sum > 35'sd32767) ? 16'sh7fff :
		(sum < -35'sd32768) ? 16'sh8000 : sum[15:0];

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:   if (in_valid) st_d = (in_data.cmd == CMD_EVAL) ? ST_E_TRK : ST_I_RD;
			ST_I_RD:   st_d = (!trk_ok || k_q >= n_q) ? ST_I_DONE : ST_I_SCAN;
			ST_I_SCAN: begin
				if (rt < req_q.time_q)
					st_d = ST_I_RD;
				else if (rt == req_q.time_q || n_q >= CW'(MAX_KEYS))
					st_d = ST_I_DONE;
				else
					st_d = ST_I_SHRD;
			end
			ST_I_SHRD: st_d = ST_I_SHWR;
			ST_I_SHWR: st_d = (j_q - CW'(1) == k_q) ? ST_I_DONE : ST_I_SHRD;
			ST_I_DONE: st_d = ST_OUT;
			ST_E_TRK: begin
				if (cnt_q[trk_q] != '0)
					st_d = ST_E_RD;
				else if (last_trk)
					st_d = pend_v_q ? ST_OUT : ST_IDLE;
			end
			ST_E_RD:   st_d = (k_q >= n_q) ? ST_E_MUL1 : ST_E_SCAN;
			ST_E_SCAN: st_d = (rt > req_q.time_q) ? ST_E_MUL1 : ST_E_RD;
			ST_E_MUL1: begin
				if (t1_q != t2_q)
					st_d = ST_E_MUL2;
				else if (last_trk)
					st_d = pend_v_q ? ST_OUT : ST_IDLE;
				else
					st_d = ST_E_TRK;
			end
			ST_E_MUL2: st_d = ST_E_DIV;
			ST_E_DIV:  if (div_done) st_d = ST_E_FIN;
			ST_E_FIN:  if (!(pend_v_q && out_stall)) st_d = last_trk ? ST_OUT : ST_E_TRK;
			ST_OUT:    if (!out_stall) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = {itrk, kidx};
		wt = req_q.time_q;
		wv = req_q.key_value;
		unique case (st_q)
			ST_I_SHRD: ram_addr = {itrk, KW'(j_q - CW'(1))};
			ST_I_SHWR: begin
				ram_we = 1'b1;
				ram_addr = {itrk, KW'(j_q)};
				wt = rt;
				wv = rv;
			end
			ST_I_DONE: ram_we = wr_q;
			ST_E_RD:   ram_addr = {trk_q, kidx};
			default: ;
		endcase
	end

	// hold the newest sample back until the next one shows whether it is last
	assign out_valid = (st_q == ST_OUT) || (st_q == ST_E_FIN && pend_v_q);

	always_comb begin
		out_data = pend_q;
		out_data.last = (st_q == ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			wen_q <= 1'b0;
			pend_v_q <= 1'b0;
			div_go_q <= 1'b0;
			for (int i = 0; i < NUM_TRACKS; i++) cnt_q[i] <= '0;
		end else begin
			st_q <= st_d;
			div_go_q <= (st_q == ST_E_MUL2);
			if (cfg_valid && cfg_ready) wen_q <= cfg_data;
			if (st_q == ST_IDLE)
				pend_v_q <= 1'b0;
			else if (st_q == ST_E_FIN && !(pend_v_q && out_stall))
				pend_v_q <= 1'b1;
			if (st_q == ST_I_DONE && add_q)
				cnt_q[itrk] <= n_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				req_q <= in_data;
				k_q <= '0;
				trk_q <= '0;
				n_q <= cnt_q[TW'(in_data.track_id)];
				wr_q <= 1'b0;
				add_q <= 1'b0;
			end
			ST_I_RD: begin
				if (trk_ok && k_q >= n_q) begin
					wr_q <= n_q < CW'(MAX_KEYS);
					add_q <= n_q < CW'(MAX_KEYS);
				end
			end
			ST_I_SCAN: begin
				if (rt < req_q.time_q) begin
					k_q <= k_q + CW'(1);
				end else if (rt == req_q.time_q) begin
					wr_q <= 1'b1;
				end else if (n_q < CW'(MAX_KEYS)) begin
					wr_q <= 1'b1;
					add_q <= 1'b1;
					j_q <= n_q;
				end
			end
			ST_I_SHWR: j_q <= j_q - CW'(1);
			ST_I_DONE: pend_q <= '{kind: 1'b0, out_track: req_q.track_id,
				sample_value: '0, status: !wr_q, last: 1'b0};
			ST_E_TRK: begin
				n_q <= cnt_q[trk_q];
				k_q <= '0;
				t1_q <= '0;
				v1_q <= '0;
				t2_q <= ONE_Q15[15:0];
				v2_q <= $signed(ONE_Q15);
				if (cnt_q[trk_q] == '0 && !last_trk) trk_q <= trk_q + TW'(1);
			end
			ST_E_SCAN: begin
				if (rt > req_q.time_q) begin
					t2_q <= rt;
					v2_q <= {rv[15], rv};
				end else begin
					t1_q <= rt;
					v1_q <= rv;
					k_q <= k_q + CW'(1);
				end
			end
			ST_E_MUL1: begin
				p1_q <= dv * dt;
				dd_q <= $signed({1'b0, t2_q} - {1'b0, t1_q});
				if (t1_q == t2_q && !last_trk) trk_q <= trk_q + TW'(1);
			end
			ST_E_MUL2: p2_q <= p1_q * $signed({2'b0, wgt});
			ST_E_FIN: begin
				if (!(pend_v_q && out_stall)) begin
					pend_q <= '{kind: 1'b1, out_track: 3'(trk_q),
						sample_value: sat, status: 1'b0, last: 1'b0};
					if (!last_trk) trk_q <= trk_q + TW'(1);
				end
			end
			default: ;
		endcase
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out dropped");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_I_DONE && add_q |-> n_q < CW'(MAX_KEYS)) else $error("count overflow");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_OUT && !out_stall |=> st_q == ST_IDLE) else $error("no return to idle");
endmodule
